### rtl/lnds_pkg.sv
package lnds_pkg;

    localparam int LNDS_DEPTH = 1024;
    localparam int LNDS_WIDTH = 32;
    localparam int LNDS_LEN_W = 11;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_UPDATE = 3'b100
    } lnds_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic update;
    } lnds_cmd_t;

    typedef struct packed {
        logic empty;
        logic more;
        logic hold;
    } lnds_status_t;

endpackage

### rtl/lnds_if.sv
interface lnds_item_if import lnds_pkg::*; #(
    parameter int WIDTH = LNDS_WIDTH
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;
    logic             last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lnds_result_if import lnds_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LNDS_LEN_W-1:0] length;
    logic                  overflow;

    modport source (output valid, output length, output overflow, input ready);
    modport sink   (input valid, input length, input overflow, output ready);
endinterface

### rtl/lnds_ctrl.sv
module lnds_ctrl import lnds_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lnds_status_t status,
    output lnds_cmd_t    cmd
);

    lnds_state_t state_reg;
    lnds_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.empty ? ST_UPDATE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.step   = 1'b1;
                state_next = status.more ? ST_SEARCH : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold a last item while the previous result has not been taken
                if (!status.hold)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lnds_dp.sv
module lnds_dp import lnds_pkg::*; #(
    parameter int DEPTH = LNDS_DEPTH,
    parameter int WIDTH = LNDS_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lnds_cmd_t             cmd,
    output lnds_status_t          status,
    input  logic [WIDTH-1:0]      value,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LNDS_LEN_W-1:0] length,
    output logic                  overflow
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [WIDTH-1:0]      mem [DEPTH];

    logic [WIDTH-1:0]      value_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      lo_reg;
    logic [CNT_W-1:0]      hi_reg;
    logic [ADDR_W-1:0]     mid_reg;
    logic [WIDTH-1:0]      rd_data_reg;
    logic [LNDS_LEN_W-1:0] len_reg;
    logic                  out_ovf_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  gt;
    logic [CNT_W-1:0]      mid_ext;
    logic [CNT_W-1:0]      lo_step;
    logic [CNT_W-1:0]      hi_step;
    logic [CNT_W:0]        mid_sum;
    logic [ADDR_W-1:0]     mid_step;
    logic [CNT_W-1:0]      count_half;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_en;
    logic                  replace;
    logic                  full;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [CNT_W-1:0]      count_after;
    logic                  ovf_after;
    logic [LNDS_LEN_W+CNT_W-1:0] len_ext;

    // one binary-search step on the tail read last cycle
    always_comb
    begin
        gt         = rd_data_reg > value_reg;
        mid_ext    = CNT_W'(mid_reg);
        lo_step    = gt ? lo_reg : CNT_W'(mid_ext + CNT_W'(1));
        hi_step    = gt ? mid_ext : hi_reg;
        mid_sum    = {1'b0, lo_step} + {1'b0, hi_step};
        mid_step   = mid_sum[ADDR_W:1];
        count_half = count_reg >> 1;
        rd_en      = cmd.load | cmd.step;
        rd_addr    = cmd.load ? count_half[ADDR_W-1:0] : mid_step;
    end

    // replace the first greater tail, else append unless full
    always_comb
    begin
        replace     = lo_reg < count_reg;
        full        = count_reg == CNT_W'(DEPTH);
        wr_en       = cmd.update & (replace | ~full);
        wr_addr     = replace ? lo_reg[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
        count_after = (!replace && !full) ? CNT_W'(count_reg + CNT_W'(1)) : count_reg;
        ovf_after   = ovf_reg | (~replace & full);
        len_ext     = {{LNDS_LEN_W{1'b0}}, count_after};
    end

    always_comb
    begin
        status.empty = count_reg == '0;
        status.more  = lo_step < hi_step;
        status.hold  = last_reg & out_valid_reg & ~out_ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.update)
        begin
            if (last_reg)
            begin
                count_next     = '0;
                ovf_next       = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                count_next = count_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last;
            lo_reg    <= '0;
            hi_reg    <= count_reg;
        end
        else if (cmd.step)
        begin
            lo_reg <= lo_step;
            hi_reg <= hi_step;
        end
        if (rd_en)
        begin
            mid_reg <= rd_addr;
        end
        if (cmd.update && last_reg)
        begin
            len_reg     <= len_ext[LNDS_LEN_W-1:0];
            out_ovf_reg <= ovf_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign length    = len_reg;
    assign overflow  = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("tail count beyond table depth");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("search step on an empty range");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |=> out_valid_reg && (count_reg == '0) && !ovf_reg)
        else $error("sequence end did not emit and clear");

endmodule

### rtl/longest_nondecreasing_subsequence.sv
// Longest non-decreasing subsequence length, patience-sorting scheme. Each request
// carries one unsigned value and a last flag; a result (length, overflow) is given
// only for the request marked last, after which the count starts again from zero.
// An item is loaded, takes s binary-search steps over the current tails, then is
// written: s is 0 when count is 0, else at most floor(log2(count)) + 1. The search
// loop is set by the single registered read port of the tail memory, one probe a
// cycle, followed by one write. The tail memory is not cleared and needs no
// start-up pass. A last item waits in its write step while the previous result
// has not yet been taken.
module longest_nondecreasing_subsequence import lnds_pkg::*; #(
    parameter int DEPTH = LNDS_DEPTH,
    parameter int WIDTH = LNDS_WIDTH
) (
    input logic             clk,
    input logic             rst_n,
    lnds_item_if.sink       items,
    lnds_result_if.source   results
);

    lnds_cmd_t    cmd;
    lnds_status_t status;

    lnds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lnds_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (items.value),
        .last      (items.last),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .length    (results.length),
        .overflow  (results.overflow)
    );

endmodule
